/* rtl/assert_macros.svh */
// assertion macros used by the checker file
// expects clk and arst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// plain condition that must hold whenever the enable is high
`define ASSERT_WHEN(label, en, cond, msg) \
	`ASSERT_CLK(label, (en) |-> (cond), msg)

`endif

/* rtl/b32_pkg.sv */
// shared types, constants and functions of the base32 stream encoder
// no dependencies
package b32_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [6:0] PAD_CHAR = 7'h3D;

	// one byte's worth of work for the emitter
	typedef struct packed {
		logic [4:0] sym0;   // first 5-bit chunk
		logic [4:0] sym1;
		logic [4:0] sym2;
		logic [1:0] nsym;   // data and flush symbols, 1..3
		logic [2:0] npad;   // trailing pad symbols, 0..6
	} job_t;

	function automatic logic [6:0] alphabet(input logic [4:0] idx);
		logic [6:0] code;
		if (idx < 5'd26) begin
			code = 7'h41 + {2'b00, idx};
		end else begin
			code = 7'h32 + {2'b00, idx} - 7'd26;
		end
		return code;
	endfunction

	// pad count to finish an eight-symbol group, by leftover bit count
	function automatic logic [2:0] pad_after(input logic [2:0] rem);
		logic [2:0] n;
		case (rem)
			3'd1: n = 3'd4;
			3'd2: n = 3'd1;
			3'd3: n = 3'd6;
			3'd4: n = 3'd3;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

/* rtl/b32_in_if.sv */
// byte input channel of the base32 encoder
// no dependencies
interface b32_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

/* rtl/b32_out_if.sv */
// symbol output channel of the base32 encoder
// no dependencies
interface b32_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] symbol;
	logic       run_last;

	modport source (output valid, output symbol, output run_last, input ready);
	modport sink (input valid, input symbol, input run_last, output ready);
endinterface

/* rtl/b32_front.sv */
// front end: takes bytes, keeps the leftover bits and turns each byte into a job
// depends on b32_pkg and b32_in_if
module b32_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pad_enable,
	b32_in_if.sink          in_ch,
	input  logic            q_full,
	output logic            push,
	output b32_pkg::job_t   push_job
);
	import b32_pkg::*;

	logic [3:0]  lb_q;
	logic [2:0]  lc_q;
	logic [2:0]  cnt;
	logic [3:0]  mask;
	logic [11:0] acc;
	logic [3:0]  total;
	logic [3:0]  shamt;
	logic [14:0] win;
	logic        two_data;
	logic [3:0]  rem_full;
	logic [2:0]  rem;
	logic        flush;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	always_comb begin
		cnt      = (lc_q > 3'd4) ? 3'd4 : lc_q;
		mask     = 4'((5'd1 << cnt) - 5'd1);
		acc      = {lb_q & mask, in_ch.data_byte};
		total    = {1'b0, cnt} + 4'd8;
		shamt    = 4'd15 - total;
		// left-justify the held bits so the chunks sit at fixed places
		win      = {3'b000, acc} << shamt[2:0];
		two_data = (total >= 4'd10);
		rem_full = two_data ? (total - 4'd10) : (total - 4'd5);
		rem      = rem_full[2:0];
		flush    = in_ch.is_last && (rem != 3'd0);

		push_job.sym0 = win[14:10];
		push_job.sym1 = win[9:5];
		push_job.sym2 = win[4:0];
		push_job.nsym = (two_data ? 2'd2 : 2'd1) + {1'b0, flush};
		push_job.npad = (flush && pad_enable) ? pad_after(rem) : 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_q <= 4'd0;
			lc_q <= 3'd0;
		end else if (push) begin
			if (in_ch.is_last) begin
				lb_q <= 4'd0;
				lc_q <= 3'd0;
			end else begin
				lb_q <= acc[3:0];
				lc_q <= rem;
			end
		end
	end

endmodule

/* rtl/b32_queue.sv */
// short job queue between the front end and the emitter
// depends on b32_pkg
module b32_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b32_pkg::job_t   push_job,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output b32_pkg::job_t   head_job
);
	import b32_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/b32_back.sv */
// emitter: walks the head job one symbol a cycle, unless out_ch stalls, into the output register
// depends on b32_pkg and b32_out_if
module b32_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  b32_pkg::job_t   head_job,
	output logic            pop,
	b32_out_if.source       out_ch
);
	import b32_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [6:0] symbol_q;
	logic       run_last_q;
	logic       load;
	logic       emit;
	logic [3:0] total;
	logic       is_end;
	logic [4:0] chunk;
	logic [6:0] next_sym;

	assign out_ch.valid    = out_valid_q;
	assign out_ch.symbol   = symbol_q;
	assign out_ch.run_last = run_last_q;

	always_comb begin
		load   = !out_valid_q || out_ch.ready;
		emit   = load && head_valid;
		total  = {2'b00, head_job.nsym} + {1'b0, head_job.npad};
		is_end = ({1'b0, idx_q} == total - 4'd1);
		case (idx_q)
			3'd0:    chunk = head_job.sym0;
			3'd1:    chunk = head_job.sym1;
			default: chunk = head_job.sym2;
		endcase
		next_sym = ({1'b0, idx_q} < {2'b00, head_job.nsym}) ? alphabet(chunk) : PAD_CHAR;
		pop      = emit && is_end;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			symbol_q   <= next_sym;
			run_last_q <= is_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (emit) begin
				idx_q <= is_end ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

endmodule

/* rtl/base32_stream_encoder.sv */
// top level of the base32 stream encoder: config register, front end, job queue, emitter
// depends on b32_pkg, b32_in_if, b32_out_if, b32_front, b32_queue, b32_back
//
//  channel   dir  payload                 handshake
//  in_ch     in   data_byte[7:0], is_last valid/ready
//  out_ch    out  symbol[6:0], run_last   valid/ready
//  cfg       in   cfg_wdata (pad_enable)  cfg_we, no wait
//
// the front end takes one byte a cycle while the two-entry job queue has room
// the emitter sends one symbol a cycle while out_ch is not stalled, so a byte yields one or two
// symbols and a last byte up to eight; the sustained rate is set by the emitter
// the first symbol of a byte reaches out_ch through the job queue and then the output register
// reset clears leftover bits, queue and output valid flag; pad_enable resets to 1
// output stalls back up through the queue into in_ch.ready
module base32_stream_encoder (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic   cfg_wdata,
	b32_in_if.sink in_ch,
	b32_out_if.source out_ch
);
	import b32_pkg::*;

	logic pad_enable_q;
	logic push;
	job_t push_job;
	logic q_full;
	logic pop;
	logic head_valid;
	job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_enable_q <= 1'b1;
		end else if (cfg_we) begin
			pad_enable_q <= cfg_wdata;
		end
	end

	b32_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pad_enable (pad_enable_q),
		.in_ch      (in_ch),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	b32_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	b32_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

/* rtl/b32_checker.sv */
// port-level checks of the base32 stream encoder, bound to the top level
// depends on b32_pkg and assert_macros.svh
`include "assert_macros.svh"

module b32_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] symbol,
	input logic       run_last
);
	import b32_pkg::*;

	logic out_xfer;
	logic out_stall;
	logic is_pad;
	logic is_code;
	logic last_done_q;

	assign out_xfer  = out_valid && out_ready;
	assign out_stall = out_valid && !out_ready;
	assign is_pad    = (symbol == PAD_CHAR);
	assign is_code   = (symbol >= 7'h41 && symbol <= 7'h5A) || (symbol >= 7'h32 && symbol <= 7'h37);

	// set once the previous run has been closed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_done_q <= 1'b1;
		end else if (out_xfer) begin
			last_done_q <= run_last;
		end
	end

	// a stalled symbol stays put
	`ASSERT_CLK(a_out_hold, out_stall |=> out_valid && $stable(symbol) && $stable(run_last), "output changed while stalled")

	// only alphabet letters, digits 2..7 or the pad character leave
	`ASSERT_WHEN(a_sym_legal, out_valid, is_code || is_pad, "illegal symbol code")

	// padding runs straight to the end of its group with no gap
	`ASSERT_CLK(a_pad_run, out_xfer && is_pad && !run_last |=> out_valid && is_pad, "padding run broken")

	// every run opens with a data symbol
	`ASSERT_WHEN(a_pad_not_first, out_valid && last_done_q, !is_pad, "pad opens a run")

endmodule

bind base32_stream_encoder b32_checker u_b32_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.symbol    (out_ch.symbol),
	.run_last  (out_ch.run_last)
);
